### rtl/ssgd_pkg.sv
// ----------------------------------------------------------------------------
// ssgd_pkg
// shared types and constants of the slider stroke gesture detector
// ----------------------------------------------------------------------------
`default_nettype none

package ssgd_pkg;

  // tick counters
  localparam int unsigned TSM_W = 8;   // ticks since motion
  localparam int unsigned TST_W = 10;  // ticks since trigger
  localparam int unsigned RT_W  = 8;   // release_ticks register
  localparam int unsigned CD_W  = 10;  // cooldown_ticks register

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STROKE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_TICKS = 3'd4;

  // reset values of the tick registers
  localparam logic [RT_W-1:0] RT_RST = 8'd30;
  localparam logic [CD_W-1:0] CD_RST = 10'd100;

  // stroke direction
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  // one result item, is_active in the lowest bit
  typedef struct packed {
    logic wake_request;
    logic engine_trigger;
    logic vibrate;
    logic ended;
    logic began;
    logic is_active;
  } ssgd_res_t;

  localparam int unsigned RES_W   = $bits(ssgd_res_t);
  localparam int unsigned M_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

### rtl/ssgd_step.sv
// ----------------------------------------------------------------------------
// ssgd_step
// next-state and result logic for one poll tick
// ----------------------------------------------------------------------------
`default_nettype none

module ssgd_step import ssgd_pkg::*; #(
  parameter int unsigned POS_FRAC_BITS = 10
) (
  // configuration
  input  wire logic [POS_FRAC_BITS:0]   deadzone_i,
  input  wire logic [POS_FRAC_BITS+1:0] min_stroke_i,
  input  wire logic [POS_FRAC_BITS:0]   travel_max_i,
  input  wire logic [RT_W-1:0]          release_ticks_i,
  input  wire logic [CD_W-1:0]          cooldown_ticks_i,
  // item
  input  wire logic                     enabled_i,
  input  wire logic                     pressed_i,
  input  wire logic                     screen_on_i,
  input  wire logic [POS_FRAC_BITS+1:0] position_i,
  // current state
  input  wire logic                     active_i,
  input  wire logic                     has_base_i,
  input  wire logic [POS_FRAC_BITS+1:0] last_pos_i,
  input  wire dir_e                     dir_i,
  input  wire logic [POS_FRAC_BITS:0]   travel_i,
  input  wire logic [TSM_W-1:0]         tsm_i,
  input  wire logic [TST_W-1:0]         tst_i,
  // next state
  output logic                          active_o,
  output logic                          has_base_o,
  output logic [POS_FRAC_BITS+1:0]      last_pos_o,
  output dir_e                          dir_o,
  output logic [POS_FRAC_BITS:0]        travel_o,
  output logic [TSM_W-1:0]              tsm_o,
  output logic [TST_W-1:0]              tst_o,
  // result
  output ssgd_res_t                     res_o
);

  localparam int unsigned POS_W = POS_FRAC_BITS + 2;
  localparam int unsigned TM_W  = POS_FRAC_BITS + 1;

  logic signed [POS_W:0] delta;
  logic        [POS_W:0] delta_abs;
  logic [POS_W-1:0]      mag;
  logic [POS_W:0]        travel_sum;
  logic                  moved;
  dir_e                  move_dir;

  assign delta      = $signed({position_i[POS_W-1], position_i})
                    - $signed({last_pos_i[POS_W-1], last_pos_i});
  assign delta_abs  = delta[POS_W] ? (~delta + 1'b1) : delta;
  assign mag        = delta_abs[POS_W-1:0];
  assign moved      = mag >= {1'b0, deadzone_i};
  // only a strictly positive change counts as upward
  assign move_dir   = (!delta[POS_W] && (delta != '0)) ? DIR_UP : DIR_DOWN;
  assign travel_sum = {2'b00, travel_i} + {1'b0, mag};

  always_comb begin
    active_o   = active_i;
    has_base_o = has_base_i;
    last_pos_o = last_pos_i;
    dir_o      = dir_i;
    travel_o   = travel_i;
    tsm_o      = (&tsm_i) ? tsm_i : tsm_i + 1'b1;
    tst_o      = (&tst_i) ? tst_i : tst_i + 1'b1;
    res_o      = '0;

    if (!enabled_i) begin
      // disable ends any session, nothing else is looked at
      if (active_i) begin
        active_o   = 1'b0;
        has_base_o = 1'b0;
        dir_o      = DIR_NONE;
        travel_o   = '0;
        res_o.ended = 1'b1;
      end
    end else begin
      if (pressed_i) begin
        res_o.wake_request = !screen_on_i;
        if (has_base_i) begin
          if (moved) begin
            tsm_o = '0;
            if (dir_i != DIR_NONE && move_dir != dir_i) begin
              // reversal
              if ({1'b0, travel_i} >= min_stroke_i) begin
                if (!active_i) begin
                  active_o = 1'b1;
                  res_o.began = 1'b1;
                  res_o.engine_trigger = 1'b1;
                  tst_o = '0;
                end
                res_o.vibrate = 1'b1;
                if (tst_o >= cooldown_ticks_i) begin
                  tst_o = '0;
                  res_o.engine_trigger = 1'b1;
                end
              end
              travel_o = '0;
              dir_o    = move_dir;
            end else begin
              res_o.vibrate = active_i;
              dir_o = move_dir;
              if (travel_sum > {2'b00, travel_max_i}) begin
                travel_o = travel_max_i;
              end else begin
                travel_o = travel_sum[TM_W-1:0];
              end
            end
          end
        end else begin
          has_base_o = 1'b1;
        end
        last_pos_o = position_i;
      end else begin
        has_base_o = 1'b0;
        dir_o      = DIR_NONE;
        travel_o   = '0;
      end
      // idle timeout
      if (active_o && tsm_o >= release_ticks_i) begin
        active_o   = 1'b0;
        has_base_o = 1'b0;
        dir_o      = DIR_NONE;
        travel_o   = '0;
        res_o.ended = 1'b1;
      end
    end
    res_o.is_active = active_o;
  end

endmodule

`default_nettype wire

### rtl/slider_stroke_gesture_detector.sv
// path: an accepted item passes the input register, then the result register
// throughput: one item per cycle unless m_axis_tready stalls; the result
//   register decouples the sides, so one more item is taken while a finished
//   result waits for m_axis_tready
// reset: asynchronous, active low; clears valids and gesture state and loads
//   the configuration registers with their default values
// ----------------------------------------------------------------------------
// slider_stroke_gesture_detector
// petting stroke detection on a touch slider, one result item per poll tick
// ----------------------------------------------------------------------------
`default_nettype none

module slider_stroke_gesture_detector import ssgd_pkg::*; #(
  parameter int unsigned POS_FRAC_BITS = 10
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,

  // configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [((POS_FRAC_BITS + 2 > CD_W) ? POS_FRAC_BITS + 2 : CD_W) - 1:0] cfg_data_i,

  // poll tick items
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // enabled, pressed, screen_on, position (signed), zero fill
  input  wire logic [((POS_FRAC_BITS + 5 + 7) / 8) * 8 - 1:0] s_axis_tdata,

  // result items
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // is_active, began, ended, vibrate, engine_trigger, wake_request, zero fill
  output logic [M_TDATA_W-1:0]        m_axis_tdata
);

  localparam int unsigned POS_W = POS_FRAC_BITS + 2;
  localparam int unsigned DZ_W  = POS_FRAC_BITS + 1;
  localparam int unsigned MS_W  = POS_FRAC_BITS + 2;
  localparam int unsigned TM_W  = POS_FRAC_BITS + 1;

  // defaults: 0.05, 0.20 (rounded up) and 1.2 (rounded) in the position format
  localparam int unsigned DzRst = (5 << POS_FRAC_BITS) / 100;
  localparam int unsigned MsRst = ((20 << POS_FRAC_BITS) + 99) / 100;
  localparam int unsigned TmRst = ((120 << POS_FRAC_BITS) + 50) / 100;

  // configuration registers
  logic [DZ_W-1:0] deadzone_q;
  logic [MS_W-1:0] min_stroke_q;
  logic [TM_W-1:0] travel_max_q;
  logic [RT_W-1:0] release_ticks_q;
  logic [CD_W-1:0] cooldown_ticks_q;

  // input register
  logic             in_valid_q;
  logic             in_en_q;
  logic             in_pr_q;
  logic             in_so_q;
  logic [POS_W-1:0] in_pos_q;

  // gesture state
  logic             active_q, active_d;
  logic             has_base_q, has_base_d;
  logic [POS_W-1:0] last_pos_q, last_pos_d;
  dir_e             dir_q, dir_d;
  logic [TM_W-1:0]  travel_q, travel_d;
  logic [TSM_W-1:0] tsm_q, tsm_d;
  logic [TST_W-1:0] tst_q, tst_d;

  // result register
  logic      out_valid_q;
  ssgd_res_t out_res_q;
  ssgd_res_t res_d;

  logic advance;  // input register hands its item to the result register
  logic in_take;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W - RES_W){1'b0}}, out_res_q};

  // configuration writes, indexes past the list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadzone_q       <= DZ_W'(DzRst);
      min_stroke_q     <= MS_W'(MsRst);
      travel_max_q     <= TM_W'(TmRst);
      release_ticks_q  <= RT_RST;
      cooldown_ticks_q <= CD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEADZONE:       deadzone_q       <= cfg_data_i[DZ_W-1:0];
        REG_MIN_STROKE:     min_stroke_q     <= cfg_data_i[MS_W-1:0];
        REG_TRAVEL_MAX:     travel_max_q     <= cfg_data_i[TM_W-1:0];
        REG_RELEASE_TICKS:  release_ticks_q  <= cfg_data_i[RT_W-1:0];
        REG_COOLDOWN_TICKS: cooldown_ticks_q <= cfg_data_i[CD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_en_q  <= s_axis_tdata[0];
      in_pr_q  <= s_axis_tdata[1];
      in_so_q  <= s_axis_tdata[2];
      in_pos_q <= s_axis_tdata[3 +: POS_W];
    end
  end

  // per-tick decision logic
  ssgd_step #(
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_step (
    .deadzone_i       (deadzone_q),
    .min_stroke_i     (min_stroke_q),
    .travel_max_i     (travel_max_q),
    .release_ticks_i  (release_ticks_q),
    .cooldown_ticks_i (cooldown_ticks_q),
    .enabled_i        (in_en_q),
    .pressed_i        (in_pr_q),
    .screen_on_i      (in_so_q),
    .position_i       (in_pos_q),
    .active_i         (active_q),
    .has_base_i       (has_base_q),
    .last_pos_i       (last_pos_q),
    .dir_i            (dir_q),
    .travel_i         (travel_q),
    .tsm_i            (tsm_q),
    .tst_i            (tst_q),
    .active_o         (active_d),
    .has_base_o       (has_base_d),
    .last_pos_o       (last_pos_d),
    .dir_o            (dir_d),
    .travel_o         (travel_d),
    .tsm_o            (tsm_d),
    .tst_o            (tst_d),
    .res_o            (res_d)
  );

  // state advances only when an item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      has_base_q <= 1'b0;
      last_pos_q <= '0;
      dir_q      <= DIR_NONE;
      travel_q   <= '0;
      tsm_q      <= '0;
      tst_q      <= '0;
    end else if (advance) begin
      active_q   <= active_d;
      has_base_q <= has_base_d;
      last_pos_q <= last_pos_d;
      dir_q      <= dir_d;
      travel_q   <= travel_d;
      tsm_q      <= tsm_d;
      tst_q      <= tst_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

### rtl/ssgd_checker.sv
// ----------------------------------------------------------------------------
// ssgd_checker
// port-level checks of the result items, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ssgd_checker import ssgd_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

  ssgd_res_t res;

  assign res = ssgd_res_t'(m_axis_tdata[RES_W-1:0]);

  // a session start leaves the detector active unless it timed out at once
  a_began_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.began |-> res.is_active || res.ended)
    else $error("began without is_active");

  // a session start always raises a touch event
  a_began_trig : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.began |-> res.engine_trigger)
    else $error("began without engine_trigger");

  // an ended session is no longer active
  a_ended_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.ended |-> !res.is_active)
    else $error("ended while active");

  // a result waiting for the sink stays put
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result item changed");

endmodule

bind slider_stroke_gesture_detector ssgd_checker u_ssgd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
